// File: rtl/ray_cone_intersection_defines.svh
// assertion macros shared by the ray versus cone intersection design
`ifndef RAY_CONE_INTERSECTION_DEFINES_SVH
`define RAY_CONE_INTERSECTION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rci_pkg.sv
// types, constants and fixed point helpers for the ray versus cone intersection
package rci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAG_W     = 62;
    localparam int HALF_W    = 31;

    typedef logic signed [63:0] t_fx;

    localparam t_fx LIM    = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam t_fx LIM_N  = -LIM;
    localparam t_fx LIM_2  = LIM / 2;
    localparam t_fx LIM_2N = -LIM_2;
    localparam t_fx LIM_4  = LIM / 4;
    localparam t_fx LIM_4N = -LIM_4;
    localparam t_fx TOL    = t_fx'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [31:0] NEG_ONE = ~(32'd1 << FRAC_BITS) + 32'd1;

    // square root over the radicand delta << FRAC_BITS
    localparam int RAD_W  = MAG_W + FRAC_BITS;
    localparam int SQ_W   = (RAD_W + 1) / 2;
    localparam int RADP_W = 2 * SQ_W;
    localparam int REM_W  = SQ_W + 2;

    // quotient bits of the root division, the rest is flagged as out of range
    localparam int QB = 32;

    // slope divider
    localparam int DQ_W   = MAG_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DQ_W);

    typedef enum logic [2:0] {
        REG_CX = 3'd0,
        REG_CY = 3'd1,
        REG_CZ = 3'd2,
        REG_R  = 3'd3,
        REG_H  = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        DS_IDLE = 3'b001,
        DS_MUL  = 3'b010,
        DS_DIV  = 3'b100
    } t_dstate;

    typedef struct packed {
        logic neg;
        logic [MAG_W-1:0] hh;
        logic [MAG_W-1:0] hl;
        logic [MAG_W-1:0] lh;
        logic [MAG_W-1:0] ll;
    } t_pp;

    typedef struct packed {
        logic ovf;
        t_fx  val;
    } t_fxr;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } t_ray;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        h;
        logic [MAG_W-1:0]   d;
        logic               dovf;
    } t_cone;

    function automatic t_fx sx(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [MAG_W-1:0] fx_mag(input t_fx x);
        t_fx m;
        m = x[63] ? -x : x;
        return m[MAG_W-1:0];
    endfunction

    // partial products of the magnitudes, four 31 by 31 multipliers
    function automatic t_pp mul_pp(input t_fx x, input t_fx y);
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        t_pp p;
        mx = fx_mag(x);
        my = fx_mag(y);
        p.neg = x[63] ^ y[63];
        p.hh = MAG_W'(mx[MAG_W-1:HALF_W]) * MAG_W'(my[MAG_W-1:HALF_W]);
        p.hl = MAG_W'(mx[MAG_W-1:HALF_W]) * MAG_W'(my[HALF_W-1:0]);
        p.lh = MAG_W'(mx[HALF_W-1:0]) * MAG_W'(my[MAG_W-1:HALF_W]);
        p.ll = MAG_W'(mx[HALF_W-1:0]) * MAG_W'(my[HALF_W-1:0]);
        return p;
    endfunction

    // sum, round half away from zero, range check
    function automatic t_fxr mul_fin(input t_pp p);
        logic [123:0] s;
        logic [123:0] q;
        logic [63:0]  m;
        t_fxr r;
        s = {p.hh, 62'd0}
            + ({61'd0, 63'(p.hl) + 63'(p.lh)} << HALF_W)
            + 124'(p.ll)
            + (124'd1 << (FRAC_BITS - 1));
        q = s >> FRAC_BITS;
        m = q[63:0];
        r.ovf = q > 124'(LIM);
        r.val = p.neg ? t_fx'(~m + 64'd1) : t_fx'(m);
        return r;
    endfunction

    function automatic t_fxr fx_add(input t_fx x, input t_fx y);
        t_fxr r;
        r.val = x + y;
        r.ovf = (r.val > LIM) || (r.val < LIM_N);
        return r;
    endfunction

endpackage

// File: rtl/ray_cone_intersection.sv
// ray versus upright cone intersection: configuration, slope divider, output buffer
//
//  channel   direction  handshake                  payload
//  ray       in         i_in_valid / o_in_ready    i_origin_*, i_direction_*
//  result    out        o_out_valid / i_out_ready  o_hit, o_distance
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one ray per cycle while o_in_ready is high (skid register empty, slope divider idle);
// the pipeline length at 16 fraction bits is set by the one-bit-per-stage square root and root division
// a write of base_radius or cone_height recomputes the slope in a multiply state and
// then the divider state, during which o_in_ready is low
// synchronous active-low reset; slope resets to 1.0 without a recompute
// a stalled result parks in a skid register, the pipeline holds while it is full
module ray_cone_intersection import rci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_direction_x,
    input  logic signed [31:0] i_direction_y,
    input  logic signed [31:0] i_direction_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic signed [31:0] o_distance,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

`include "ray_cone_intersection_defines.svh"

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_r, r_h;

    t_dstate            r_dstate;
    logic [DQ_W-1:0]    r_dnum;
    logic [MAG_W-1:0]   r_dden;
    logic [MAG_W-1:0]   r_drem;
    logic [MAG_W-1:0]   r_dq;
    logic               r_dsticky;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [MAG_W-1:0]   r_d;
    logic               r_dovf;

    logic [MAG_W:0]     n_drem2;
    logic               n_dge;
    logic [MAG_W:0]     n_drem;

    always_comb begin
        n_drem2 = {r_drem, r_dnum[DQ_W-1]};
        n_dge   = n_drem2 >= {1'b0, r_dden};
        n_drem  = n_dge ? n_drem2 - {1'b0, r_dden} : n_drem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_r      <= 31'(64'd1 << FRAC_BITS);
            r_h      <= 31'(64'd1 << FRAC_BITS);
            r_dstate <= DS_IDLE;
            r_dcnt   <= '0;
            r_d      <= MAG_W'(64'd1 << FRAC_BITS);
            r_dovf   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_CX:  r_cx <= i_cfg_data;
                    REG_CY:  r_cy <= i_cfg_data;
                    REG_CZ:  r_cz <= i_cfg_data;
                    REG_R:   r_r  <= i_cfg_data[30:0];
                    REG_H:   r_h  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // slope (r/h)^2, restoring division one bit per cycle
            if (i_cfg_we && (i_cfg_idx == REG_R || i_cfg_idx == REG_H)) begin
                r_dstate <= DS_MUL;
            end else begin
                case (r_dstate)
                    DS_IDLE: ;
                    DS_MUL: begin
                        r_dcnt   <= '0;
                        r_dstate <= DS_DIV;
                    end
                    DS_DIV: begin
                        r_dcnt <= r_dcnt + 1'b1;
                        if (r_dcnt == DCNT_W'(DQ_W - 1)) begin
                            r_d      <= {r_dq[MAG_W-2:0], n_dge};
                            r_dovf   <= r_dsticky || r_dq[MAG_W-1];
                            r_dstate <= DS_IDLE;
                        end
                    end
                    default: r_dstate <= DS_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_dstate)
            DS_MUL: begin
                r_dnum    <= {MAG_W'(r_r) * MAG_W'(r_r), {FRAC_BITS{1'b0}}};
                r_dden    <= MAG_W'(r_h) * MAG_W'(r_h);
                r_drem    <= '0;
                r_dq      <= '0;
                r_dsticky <= 1'b0;
            end
            DS_DIV: begin
                r_dnum    <= r_dnum << 1;
                r_drem    <= n_drem[MAG_W-1:0];
                r_dq      <= {r_dq[MAG_W-2:0], n_dge};
                r_dsticky <= r_dsticky || r_dq[MAG_W-1];
            end
            default: ;
        endcase
    end

    // pipeline and output buffer
    logic        r_ov, r_ohit, r_sv, r_shit;
    logic [31:0] r_odist, r_sdist;
    logic        en;
    logic        c_vld, c_hit;
    logic [31:0] c_dist;
    t_ray        ray;
    t_cone       cone;

    assign en         = !r_sv;
    assign o_in_ready = en && (r_dstate == DS_IDLE);

    assign ray.ox = i_origin_x;
    assign ray.oy = i_origin_y;
    assign ray.oz = i_origin_z;
    assign ray.dx = i_direction_x;
    assign ray.dy = i_direction_y;
    assign ray.dz = i_direction_z;

    assign cone.cx   = r_cx;
    assign cone.cy   = r_cy;
    assign cone.cz   = r_cz;
    assign cone.h    = r_h;
    assign cone.d    = r_d;
    assign cone.dovf = r_dovf;

    rci_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid && o_in_ready),
        .i_ray   (ray),
        .i_cone  (cone),
        .o_vld   (c_vld),
        .o_hit   (c_hit),
        .o_dist  (c_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_out_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= en && c_vld;
            end
        end else if (en && c_vld) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_out_ready) begin
            if (r_sv) begin
                r_ohit  <= r_shit;
                r_odist <= r_sdist;
            end else begin
                r_ohit  <= c_hit;
                r_odist <= c_dist;
            end
        end else if (en && c_vld) begin
            r_shit  <= c_hit;
            r_sdist <= c_dist;
        end
    end

    assign o_out_valid = r_ov;
    assign o_hit       = r_ohit;
    assign o_distance  = r_odist;

    // last divider step with no write in the same cycle
    logic div_end;
    assign div_end = (r_dstate == DS_DIV) && (r_dcnt == DCNT_W'(DQ_W - 1)) && !i_cfg_we;

    `RCI_ASSERT_IMP(a_skid_ov, i_clk, i_rst_n, r_sv, r_ov, "skid full while output empty")
    `RCI_ASSERT_IMP(a_busy_rdy, i_clk, i_rst_n, r_dstate != DS_IDLE, !o_in_ready, "busy ready")
    `RCI_ASSERT_IMP(a_miss_dist, i_clk, i_rst_n, r_ov && !r_ohit, r_odist == NEG_ONE, "bad miss")
    `RCI_ASSERT_NXT(a_div_done, i_clk, i_rst_n, div_end, r_dstate == DS_IDLE, "divider stuck")

endmodule

// File: rtl/rci_core.sv
// intersection pipeline: quadratic, discriminant, square root, root division, height test
module rci_core import rci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_ray        i_ray,
    input  t_cone       i_cone,
    output logic        o_vld,
    output logic        o_hit,
    output logic [31:0] o_dist
);

    localparam int NST = 14 + SQ_W + QB;

    typedef struct packed {
        logic               miss;
        logic               aneg;
        t_fx                b;
        logic [MAG_W:0]     den;
        logic signed [31:0] dy;
        logic signed [31:0] oy;
    } t_sqc;

    typedef struct packed {
        logic               miss;
        logic               qneg;
        logic [MAG_W:0]     den;
        logic signed [31:0] dy;
        logic signed [31:0] oy;
    } t_dvc;

    logic [NST-1:0] r_vld;

    t_fx d_fx;
    assign d_fx = t_fx'({2'b00, i_cone.d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // stages 1 to 9: coefficients and discriminant
    t_fx r1_a, r1_b, r1_c;
    logic signed [31:0] r1_dx, r1_dy, r1_dz, r1_oy;
    t_pp r2_xx, r2_zz, r2_yy, r2_ax, r2_bz, r2_dc, r2_aa, r2_bb, r2_cc;
    logic signed [31:0] r2_dy, r2_oy;
    t_fxr r3_xx, r3_zz, r3_yy, r3_ax, r3_bz, r3_dc, r3_aa, r3_bb, r3_cc;
    logic signed [31:0] r3_dy, r3_oy;
    t_fxr r4_s1, r4_s2, r4_s3;
    t_pp r4_dyy, r4_dcy, r4_dcc;
    logic r4_ovf;
    logic signed [31:0] r4_oy, r4_dy;
    t_fxr r5_s1, r5_s2, r5_s3, r5_dyy, r5_dcy, r5_dcc;
    logic r5_ovf;
    logic signed [31:0] r5_oy, r5_dy;
    t_fx r6_a, r6_b, r6_c;
    logic r6_ovf;
    logic signed [31:0] r6_oy, r6_dy;
    t_pp r7_bb, r7_ac;
    t_fx r7_a, r7_b;
    logic r7_ovf;
    logic signed [31:0] r7_oy, r7_dy;
    t_fxr r8_bb, r8_ac;
    t_fx r8_a, r8_b;
    logic r8_ovf;
    logic signed [31:0] r8_oy, r8_dy;

    t_fxr n6_a, n6_b0, n6_c;
    logic n6_bsc;
    logic n9_ac4, n9_den;
    t_fx  n9_ac;
    t_fxr n9_dl;
    logic n9_miss;

    always_comb begin
        n6_a   = fx_add(r5_s1.val, -r5_dyy.val);
        n6_b0  = fx_add(r5_s2.val, r5_dcy.val);
        n6_c   = fx_add(r5_s3.val, -r5_dcc.val);
        n6_bsc = (n6_b0.val > LIM_2) || (n6_b0.val < LIM_2N);

        n9_ac4 = (r8_ac.val > LIM_4) || (r8_ac.val < LIM_4N);
        n9_ac  = r8_ac.val <<< 2;
        n9_dl  = fx_add(r8_bb.val, -n9_ac);
        n9_den = (r8_a > LIM_2) || (r8_a < LIM_2N);
        n9_miss = r8_ovf || r8_bb.ovf || r8_ac.ovf || n9_ac4 || n9_dl.ovf || n9_den
            || (n9_dl.val < TOL) || (n9_dl.val < 0) || (r8_a == 0);
    end

    logic [RADP_W-1:0] r_sq_rad  [SQ_W+1];
    logic [REM_W-1:0]  r_sq_rem  [SQ_W+1];
    logic [SQ_W-1:0]   r_sq_root [SQ_W+1];
    t_sqc              r_sq_car  [SQ_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= sx(i_ray.ox) - sx(i_cone.cx);
            r1_b  <= sx(i_ray.oz) - sx(i_cone.cz);
            r1_c  <= t_fx'({33'd0, i_cone.h}) - sx(i_ray.oy) + sx(i_cone.cy);
            r1_dx <= i_ray.dx;
            r1_dy <= i_ray.dy;
            r1_dz <= i_ray.dz;
            r1_oy <= i_ray.oy;

            r2_xx <= mul_pp(sx(r1_dx), sx(r1_dx));
            r2_zz <= mul_pp(sx(r1_dz), sx(r1_dz));
            r2_yy <= mul_pp(sx(r1_dy), sx(r1_dy));
            r2_ax <= mul_pp(r1_a, sx(r1_dx));
            r2_bz <= mul_pp(r1_b, sx(r1_dz));
            r2_dc <= mul_pp(d_fx, r1_c);
            r2_aa <= mul_pp(r1_a, r1_a);
            r2_bb <= mul_pp(r1_b, r1_b);
            r2_cc <= mul_pp(r1_c, r1_c);
            r2_dy <= r1_dy;
            r2_oy <= r1_oy;

            r3_xx <= mul_fin(r2_xx);
            r3_zz <= mul_fin(r2_zz);
            r3_yy <= mul_fin(r2_yy);
            r3_ax <= mul_fin(r2_ax);
            r3_bz <= mul_fin(r2_bz);
            r3_dc <= mul_fin(r2_dc);
            r3_aa <= mul_fin(r2_aa);
            r3_bb <= mul_fin(r2_bb);
            r3_cc <= mul_fin(r2_cc);
            r3_dy <= r2_dy;
            r3_oy <= r2_oy;

            r4_s1  <= fx_add(r3_xx.val, r3_zz.val);
            r4_s2  <= fx_add(r3_ax.val, r3_bz.val);
            r4_s3  <= fx_add(r3_aa.val, r3_bb.val);
            r4_dyy <= mul_pp(d_fx, r3_yy.val);
            r4_dcy <= mul_pp(r3_dc.val, sx(r3_dy));
            r4_dcc <= mul_pp(d_fx, r3_cc.val);
            r4_ovf <= i_cone.dovf || r3_xx.ovf || r3_zz.ovf || r3_yy.ovf || r3_ax.ovf
                || r3_bz.ovf || r3_dc.ovf || r3_aa.ovf || r3_bb.ovf || r3_cc.ovf;
            r4_dy  <= r3_dy;
            r4_oy  <= r3_oy;

            r5_s1  <= r4_s1;
            r5_s2  <= r4_s2;
            r5_s3  <= r4_s3;
            r5_dyy <= mul_fin(r4_dyy);
            r5_dcy <= mul_fin(r4_dcy);
            r5_dcc <= mul_fin(r4_dcc);
            r5_ovf <= r4_ovf || r4_s1.ovf || r4_s2.ovf || r4_s3.ovf;
            r5_dy  <= r4_dy;
            r5_oy  <= r4_oy;

            r6_a   <= n6_a.val;
            r6_b   <= n6_b0.val <<< 1;
            r6_c   <= n6_c.val;
            r6_ovf <= r5_ovf || r5_dyy.ovf || r5_dcy.ovf || r5_dcc.ovf
                || n6_a.ovf || n6_b0.ovf || n6_c.ovf || n6_bsc;
            r6_dy  <= r5_dy;
            r6_oy  <= r5_oy;

            r7_bb  <= mul_pp(r6_b, r6_b);
            r7_ac  <= mul_pp(r6_a, r6_c);
            r7_a   <= r6_a;
            r7_b   <= r6_b;
            r7_ovf <= r6_ovf;
            r7_dy  <= r6_dy;
            r7_oy  <= r6_oy;

            r8_bb  <= mul_fin(r7_bb);
            r8_ac  <= mul_fin(r7_ac);
            r8_a   <= r7_a;
            r8_b   <= r7_b;
            r8_ovf <= r7_ovf;
            r8_dy  <= r7_dy;
            r8_oy  <= r7_oy;

            // stage 9 seeds the square root
            r_sq_rad[0]      <= RADP_W'({n9_dl.val[MAG_W-1:0], {FRAC_BITS{1'b0}}});
            r_sq_rem[0]      <= '0;
            r_sq_root[0]     <= '0;
            r_sq_car[0].miss <= n9_miss;
            r_sq_car[0].aneg <= r8_a[63];
            r_sq_car[0].b    <= r8_b;
            r_sq_car[0].den  <= {fx_mag(r8_a), 1'b0};
            r_sq_car[0].dy   <= r8_dy;
            r_sq_car[0].oy   <= r8_oy;
        end
    end

    // square root, one root bit per stage
    for (genvar k = 0; k < SQ_W; k++) begin : g_sq
        logic [REM_W+1:0] rem2;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] rem_n;
        logic             ge;

        always_comb begin
            rem2  = {r_sq_rem[k], r_sq_rad[k][RADP_W-1 -: 2]};
            trial = (REM_W+2)'({r_sq_root[k], 2'b01});
            ge    = rem2 >= trial;
            rem_n = ge ? rem2 - trial : rem2;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
                r_sq_rem[k+1]  <= rem_n[REM_W-1:0];
                r_sq_root[k+1] <= {r_sq_root[k][SQ_W-2:0], ge};
                r_sq_car[k+1]  <= r_sq_car[k];
            end
        end
    end

    // numerator of the nearer root and the range test of the quotient
    t_fx              n_s;
    t_fxr             n_num;
    logic [MAG_W-1:0] n_nm;
    logic             n_big;

    always_comb begin
        n_s   = t_fx'({{(64-SQ_W){1'b0}}, r_sq_root[SQ_W]});
        n_num = r_sq_car[SQ_W].aneg ? fx_add(-r_sq_car[SQ_W].b, n_s)
                                    : fx_add(-r_sq_car[SQ_W].b, -n_s);
        n_nm  = fx_mag(n_num.val);
        n_big = (MAG_W+1)'(n_nm >> (QB - FRAC_BITS)) >= r_sq_car[SQ_W].den;
    end

    logic [MAG_W:0]  r_dv_rem  [QB+1];
    logic [QB-1:0]   r_dv_feed [QB+1];
    logic [QB-1:0]   r_dv_q    [QB+1];
    t_dvc            r_dv_car  [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_rem[0]      <= (MAG_W+1)'(n_nm >> (QB - FRAC_BITS));
            r_dv_feed[0]     <= {n_nm[QB-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_dv_q[0]        <= '0;
            r_dv_car[0].miss <= r_sq_car[SQ_W].miss || n_num.ovf || n_big;
            r_dv_car[0].qneg <= n_num.val[63] ^ r_sq_car[SQ_W].aneg;
            r_dv_car[0].den  <= r_sq_car[SQ_W].den;
            r_dv_car[0].dy   <= r_sq_car[SQ_W].dy;
            r_dv_car[0].oy   <= r_sq_car[SQ_W].oy;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_dv
        logic [MAG_W+1:0] rem2;
        logic [MAG_W+1:0] rem_n;
        logic             ge;

        always_comb begin
            rem2  = {r_dv_rem[k], r_dv_feed[k][QB-1]};
            ge    = rem2 >= {1'b0, r_dv_car[k].den};
            rem_n = ge ? rem2 - {1'b0, r_dv_car[k].den} : rem2;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[k+1]  <= rem_n[MAG_W:0];
                r_dv_feed[k+1] <= r_dv_feed[k] << 1;
                r_dv_q[k+1]    <= {r_dv_q[k][QB-2:0], ge};
                r_dv_car[k+1]  <= r_dv_car[k];
            end
        end
    end

    // signed root, height of the hit point, band test
    logic [31:0] n_q;
    logic        n_fit;
    logic [31:0] n_dym;
    logic [63:0] n_rm;
    t_fx         n_top;

    logic [31:0]        r_t;
    logic [31:0]        r_tq;
    logic               r_tmiss;
    logic signed [31:0] r_tdy, r_toy;
    logic [63:0]        r_pm;
    logic               r_pneg;
    logic [31:0]        r_pt;
    logic               r_pmiss;
    logic signed [31:0] r_poy;
    t_fx                r_yh;
    logic [31:0]        r_yt;
    logic               r_ymiss;
    logic               r_hit;
    logic [31:0]        r_dist;

    always_comb begin
        n_q   = r_dv_q[QB];
        n_fit = r_dv_car[QB].qneg ? (n_q <= 32'h8000_0000) : !n_q[31];
        n_dym = r_tdy[31] ? ~r_tdy + 32'd1 : r_tdy;
        n_rm  = (r_pm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_top = sx(i_cone.cy) + t_fx'({33'd0, i_cone.h});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= r_dv_car[QB].qneg ? ~n_q + 32'd1 : n_q;
            r_tq    <= n_q;
            r_tmiss <= r_dv_car[QB].miss || !n_fit;
            r_tdy   <= r_dv_car[QB].dy;
            r_toy   <= r_dv_car[QB].oy;

            r_pm    <= {32'd0, n_dym} * {32'd0, r_tq};
            r_pneg  <= r_tdy[31] ^ r_t[31];
            r_pt    <= r_t;
            r_pmiss <= r_tmiss;
            r_poy   <= r_toy;

            r_yh    <= sx(r_poy) + (r_pneg ? t_fx'(~n_rm + 64'd1) : t_fx'(n_rm));
            r_yt    <= r_pt;
            r_ymiss <= r_pmiss;

            r_hit   <= !r_ymiss && (n_top > r_yh) && (sx(i_cone.cy) < r_yh);
            r_dist  <= (!r_ymiss && (n_top > r_yh) && (sx(i_cone.cy) < r_yh)) ? r_yt : NEG_ONE;
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_hit  = r_hit;
    assign o_dist = r_dist;

endmodule
